FILE: hw/rtl/msc_pkg.sv
// Shared constants, microcode types and the control store for the microphone
// sample conditioner. No dependencies; imported by mic_sample_conditioner_core.
package msc_pkg;

    // Defaults for the top-level parameters
    localparam int RAW_SHIFT_DEF = 14;
    localparam int FRAC_BITS_DEF = 20;

    // Filter state widths and coefficients
    localparam int DC_W         = 38;
    localparam int XIN_W        = 39;
    localparam int YOUT_W       = 42;
    localparam int DC_COEF_BITS = 24;
    localparam int HP_COEF_BITS = 16;
    localparam int GAIN_BITS    = 8;
    localparam logic [15:0] DC_COEF = 16'd16777;  // 0.001 in Q0.24
    localparam logic [15:0] HP_COEF = 16'd64160;  // 0.979 in Q0.16

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SELECT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Q8        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_THRESHOLD = 2'd2;

    // Stream words
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 16;

    // Gate divider
    localparam int QUO_W     = 15;
    localparam int DIV_CNT_W = 4;

    // Microcode
    localparam int UPC_W = 5;

    typedef enum logic [4:0] {
        OP_LOAD,
        OP_MUL_DC,
        OP_DC_UPD,
        OP_XIN,
        OP_HP_SUM,
        OP_MUL_HP,
        OP_HP_UPD,
        OP_MUL_GAIN,
        OP_MAG,
        OP_SETR,
        OP_SQ_LO,
        OP_SQ_HI,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_GATE_OUT,
        OP_UNGATED,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_GOTO,
        COND_NOGATE,
        COND_LOOP,
        COND_END
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [UPC_W-1:0]  target;
    } t_cword;

    localparam logic [UPC_W-1:0] STEP_DIV     = 5'd13;
    localparam logic [UPC_W-1:0] STEP_UNGATED = 5'd15;
    localparam logic [UPC_W-1:0] STEP_EMIT    = 5'd16;

    // Control store: one word per step
    function automatic t_cword ucode_rom(input logic [UPC_W-1:0] addr);
        t_cword cw;
        cw = '{op: OP_EMIT, cond: COND_END, target: '0};
        case (addr)
            5'd0:  cw = '{op: OP_LOAD,     cond: COND_NEXT,   target: '0};
            5'd1:  cw = '{op: OP_MUL_DC,   cond: COND_NEXT,   target: '0};
            5'd2:  cw = '{op: OP_DC_UPD,   cond: COND_NEXT,   target: '0};
            5'd3:  cw = '{op: OP_XIN,      cond: COND_NEXT,   target: '0};
            5'd4:  cw = '{op: OP_HP_SUM,   cond: COND_NEXT,   target: '0};
            5'd5:  cw = '{op: OP_MUL_HP,   cond: COND_NEXT,   target: '0};
            5'd6:  cw = '{op: OP_HP_UPD,   cond: COND_NEXT,   target: '0};
            5'd7:  cw = '{op: OP_MUL_GAIN, cond: COND_NEXT,   target: '0};
            5'd8:  cw = '{op: OP_MAG,      cond: COND_NEXT,   target: '0};
            5'd9:  cw = '{op: OP_SETR,     cond: COND_NOGATE, target: STEP_UNGATED};
            5'd10: cw = '{op: OP_SQ_LO,    cond: COND_NEXT,   target: '0};
            5'd11: cw = '{op: OP_SQ_HI,    cond: COND_NEXT,   target: '0};
            5'd12: cw = '{op: OP_DIV_INIT, cond: COND_NEXT,   target: '0};
            5'd13: cw = '{op: OP_DIV_STEP, cond: COND_LOOP,   target: STEP_DIV};
            5'd14: cw = '{op: OP_GATE_OUT, cond: COND_GOTO,   target: STEP_EMIT};
            5'd15: cw = '{op: OP_UNGATED,  cond: COND_NEXT,   target: '0};
            5'd16: cw = '{op: OP_EMIT,     cond: COND_END,    target: '0};
            default: cw = '{op: OP_EMIT,   cond: COND_END,    target: '0};
        endcase
        return cw;
    endfunction

endpackage

FILE: hw/rtl/mic_sample_conditioner_core.sv
// Microphone sample conditioner: DC removal, one-pole high-pass, gain, soft
// noise gate and clamp, run by a microcoded sequencer. Depends on msc_pkg.
// The sequencer accepts no new word until the previous one has been emitted,
// so the gate's 15-step restoring divider and the single shared multiplier
// set the pace; the ungated path skips the squaring and the divider.
// Reset (synchronous, active low): filter state zero, gain unity, gate off.
module mic_sample_conditioner_core #(
    parameter int RAW_SHIFT = msc_pkg::RAW_SHIFT_DEF,
    parameter int FRAC_BITS = msc_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration writes
    input  logic                              i_cfg_we,
    input  logic [msc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [msc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // Input frames
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [msc_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,  // left_word, right_word
    input  logic                              i_s_axis_tlast,  // block_end
    // Conditioned samples
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [msc_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,  // sample_out
    output logic                              o_m_axis_tlast   // block_end_out
);
    import msc_pkg::*;

    // Working widths follow from the raw shift and the state scaling
    localparam int RAW_W  = 32 - RAW_SHIFT;
    localparam int RQ_W   = RAW_W + FRAC_BITS;
    localparam int DIFF_W = (RQ_W > DC_W ? RQ_W : DC_W) + 1;
    localparam int HS_W   = YOUT_W + 2;
    localparam int MA_W   = DIFF_W > HS_W ? DIFF_W : HS_W;
    localparam int MB_W   = 17;
    localparam int PR_W   = MA_W + MB_W;
    localparam int ACC_W  = PR_W > 64 ? PR_W : 64;
    localparam int MAG_W  = YOUT_W + 16;
    localparam int GSH    = FRAC_BITS + GAIN_BITS;   // gained sample fraction bits
    localparam int RSH    = GSH - 16;                // floor to Q.16
    localparam int R_W    = 31;
    localparam int SQ_LSB = 32;
    localparam int SQH_W  = 2 * QUO_W;

    localparam logic signed [ACC_W-1:0] DC_HALF  = ACC_W'(1) << (DC_COEF_BITS - 1);
    localparam logic signed [ACC_W-1:0] HP_HALF  = ACC_W'(1) << (HP_COEF_BITS - 1);
    localparam logic signed [ACC_W-1:0] DC_MAX   = (ACC_W'(1) << (DC_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] XIN_MAX  = (ACC_W'(1) << (XIN_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] YOUT_MAX = (ACC_W'(1) << (YOUT_W - 1)) - ACC_W'(1);
    localparam logic [QUO_W-1:0]        OUT_MAX  = '1;

    // Clamp to [-vmax-1, vmax]
    function automatic logic signed [ACC_W-1:0] sat_acc(
        input logic signed [ACC_W-1:0] v,
        input logic signed [ACC_W-1:0] vmax
    );
        logic signed [ACC_W-1:0] vmin;
        vmin = -vmax - ACC_W'(1);
        if (v > vmax) begin
            return vmax;
        end else if (v < vmin) begin
            return vmin;
        end
        return v;
    endfunction

    // Configuration
    logic                    r_slot, n_slot;
    logic [15:0]             r_gain, n_gain;
    logic [QUO_W-1:0]        r_thr, n_thr;
    // Sequencer
    logic                    r_busy, n_busy;
    logic [UPC_W-1:0]        r_upc, n_upc;
    // Frame capture
    logic signed [RAW_W-1:0] r_raw, n_raw;
    logic                    r_last, n_last;
    // Filter state
    logic signed [DC_W-1:0]   r_dc, n_dc;
    logic signed [XIN_W-1:0]  r_xin, n_xin;
    logic signed [YOUT_W-1:0] r_yout, n_yout;
    // Datapath scratch
    logic signed [XIN_W-1:0]  r_x, n_x;
    logic signed [MA_W-1:0]   r_t, n_t;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic [MAG_W-1:0]         r_mag, n_mag;
    logic                     r_neg, n_neg;
    // Gate divider
    logic [QUO_W-1:0]         r_rem, n_rem;
    logic [QUO_W-1:0]         r_num, n_num;
    logic [QUO_W-1:0]         r_quo, n_quo;
    logic [DIV_CNT_W-1:0]     r_cnt, n_cnt;
    logic [15:0]              r_res, n_res;
    // Output word
    logic                     r_out_valid, n_out_valid;
    logic [15:0]              r_out_data, n_out_data;
    logic                     r_out_last, n_out_last;

    t_cword                   w_cw;
    logic                     w_accept;
    logic signed [31:0]       w_word;
    logic signed [RQ_W-1:0]   w_rawq;
    logic [15:0]              w_mul_b;
    logic signed [PR_W-1:0]   w_prod;
    logic signed [ACC_W-1:0]  w_dc_rnd, w_dc_sat;
    logic signed [ACC_W-1:0]  w_xsat;
    logic signed [ACC_W-1:0]  w_hp_rnd, w_ysat;
    logic [ACC_W-1:0]         w_abs;
    logic                     w_gate;
    logic [SQH_W-1:0]         w_sq_hi;
    logic [QUO_W:0]           w_trial;
    logic                     w_qbit;
    logic [MAG_W-1:0]         w_ires;
    logic [QUO_W-1:0]         w_ures;
    logic                     w_out_busy;

    assign w_cw     = ucode_rom(r_upc);
    assign w_accept = i_s_axis_tvalid && !r_busy;
    assign w_word   = r_slot ? $signed(i_s_axis_tdata[63:32]) : $signed(i_s_axis_tdata[31:0]);
    assign w_rawq   = $signed({r_raw, {FRAC_BITS{1'b0}}});

    // Shared multiplier: scratch operand times a coefficient, the gain, or a slice
    // of the scratch itself for the squaring
    always_comb begin
        case (w_cw.op)
            OP_MUL_DC:   w_mul_b = DC_COEF;
            OP_MUL_HP:   w_mul_b = HP_COEF;
            OP_MUL_GAIN: w_mul_b = r_gain;
            OP_SQ_LO:    w_mul_b = r_t[15:0];
            OP_SQ_HI:    w_mul_b = {1'b0, r_t[R_W-1:16]};
            default:     w_mul_b = '0;
        endcase
    end
    assign w_prod = r_t * $signed({1'b0, w_mul_b});

    // Rounding (half up) and saturation of the filter updates
    assign w_dc_rnd = (r_acc + DC_HALF) >>> DC_COEF_BITS;
    assign w_dc_sat = sat_acc(w_dc_rnd + ACC_W'(r_dc), DC_MAX);
    assign w_xsat   = sat_acc(ACC_W'(w_rawq) - ACC_W'(r_dc), XIN_MAX);
    assign w_hp_rnd = (r_acc + HP_HALF) >>> HP_COEF_BITS;
    assign w_ysat   = sat_acc(w_hp_rnd, YOUT_MAX);
    assign w_abs    = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);

    // Gate applies when enabled and the gained magnitude is under the threshold
    assign w_gate  = (r_thr != '0) && (r_mag < (MAG_W'(r_thr) << GSH));
    // Quotient of r*r by threshold<<32 only needs the square's top bits
    assign w_sq_hi = r_acc[SQ_LSB +: SQH_W];
    assign w_trial = {r_rem, r_num[QUO_W-1]};
    assign w_qbit  = w_trial >= {1'b0, r_thr};
    assign w_ires  = r_mag >> GSH;
    assign w_ures  = (w_ires > MAG_W'(OUT_MAX)) ? OUT_MAX : w_ires[QUO_W-1:0];
    assign w_out_busy = r_out_valid && !i_m_axis_tready;

    always_comb begin
        n_slot      = r_slot;
        n_gain      = r_gain;
        n_thr       = r_thr;
        n_busy      = r_busy;
        n_upc       = r_upc;
        n_raw       = r_raw;
        n_last      = r_last;
        n_dc        = r_dc;
        n_xin       = r_xin;
        n_yout      = r_yout;
        n_x         = r_x;
        n_t         = r_t;
        n_acc       = r_acc;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_rem       = r_rem;
        n_num       = r_num;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        // Drop the output word once taken
        n_out_valid = r_out_valid && !i_m_axis_tready;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SLOT_SELECT:    n_slot = i_cfg_wdata[0];
                CFG_GAIN_Q8:        n_gain = i_cfg_wdata;
                CFG_GATE_THRESHOLD: n_thr  = i_cfg_wdata[QUO_W-1:0];
                default: ;
            endcase
        end

        if (w_accept) begin
            // Capture the chosen slot already shifted down to the raw sample
            n_raw  = w_word[31:RAW_SHIFT];
            n_last = i_s_axis_tlast;
            n_busy = 1'b1;
            n_upc  = '0;
        end else if (r_busy) begin
            case (w_cw.op)
                OP_LOAD:     n_t   = MA_W'(w_rawq) - MA_W'(r_dc);
                OP_MUL_DC:   n_acc = ACC_W'(w_prod);
                OP_DC_UPD:   n_dc  = w_dc_sat[DC_W-1:0];
                OP_XIN:      n_x   = w_xsat[XIN_W-1:0];
                OP_HP_SUM: begin
                    n_t   = MA_W'(r_yout) + MA_W'(r_x) - MA_W'(r_xin);
                    n_xin = r_x;
                end
                OP_MUL_HP:   n_acc = ACC_W'(w_prod);
                OP_HP_UPD: begin
                    n_yout = w_ysat[YOUT_W-1:0];
                    n_t    = w_ysat[MA_W-1:0];
                end
                OP_MUL_GAIN: n_acc = ACC_W'(w_prod);
                OP_MAG: begin
                    n_neg = r_acc[ACC_W-1];
                    n_mag = w_abs[MAG_W-1:0];
                end
                OP_SETR:     n_t   = $signed(MA_W'(r_mag[RSH +: R_W]));
                OP_SQ_LO:    n_acc = ACC_W'(w_prod);
                OP_SQ_HI:    n_acc = r_acc + (ACC_W'(w_prod) <<< 16);
                OP_DIV_INIT: begin
                    // Top half stays below the threshold since the quotient fits
                    n_rem = w_sq_hi[SQH_W-1:QUO_W];
                    n_num = w_sq_hi[QUO_W-1:0];
                    n_quo = '0;
                    n_cnt = DIV_CNT_W'(QUO_W - 1);
                end
                OP_DIV_STEP: begin
                    n_rem = w_qbit ? QUO_W'(w_trial - {1'b0, r_thr}) : w_trial[QUO_W-1:0];
                    n_num = {r_num[QUO_W-2:0], 1'b0};
                    n_quo = {r_quo[QUO_W-2:0], w_qbit};
                    n_cnt = r_cnt - DIV_CNT_W'(1);
                end
                OP_GATE_OUT: n_res = r_neg ? 16'(-{1'b0, r_quo}) : {1'b0, r_quo};
                OP_UNGATED:  n_res = r_neg ? 16'(-{1'b0, w_ures}) : {1'b0, w_ures};
                OP_EMIT: begin
                    // Hold here while the previous word still waits
                    if (!w_out_busy) begin
                        n_out_valid = 1'b1;
                        n_out_data  = r_res;
                        n_out_last  = r_last;
                    end
                end
                default: ;
            endcase

            case (w_cw.cond)
                COND_NEXT:   n_upc = r_upc + UPC_W'(1);
                COND_GOTO:   n_upc = w_cw.target;
                COND_NOGATE: n_upc = w_gate ? r_upc + UPC_W'(1) : w_cw.target;
                COND_LOOP:   n_upc = (r_cnt != '0) ? w_cw.target : r_upc + UPC_W'(1);
                COND_END: begin
                    if (!w_out_busy) begin
                        n_busy = 1'b0;
                        n_upc  = '0;
                    end
                end
                default:     n_upc = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= 1'b0;
            r_gain      <= 16'd256;
            r_thr       <= '0;
            r_busy      <= 1'b0;
            r_upc       <= '0;
            r_dc        <= '0;
            r_xin       <= '0;
            r_yout      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_slot      <= n_slot;
            r_gain      <= n_gain;
            r_thr       <= n_thr;
            r_busy      <= n_busy;
            r_upc       <= n_upc;
            r_dc        <= n_dc;
            r_xin       <= n_xin;
            r_yout      <= n_yout;
            r_out_valid <= n_out_valid;
        end
        r_raw      <= n_raw;
        r_last     <= n_last;
        r_x        <= n_x;
        r_t        <= n_t;
        r_acc      <= n_acc;
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_rem      <= n_rem;
        r_num      <= n_num;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_res      <= n_res;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_s_axis_tready = !r_busy;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // An accepted frame starts the program at its first step
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy && (r_upc == '0))
        else $error("sequencer did not start at step zero");

    // The step counter never leaves the control store
    a_upc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_upc <= STEP_EMIT))
        else $error("step counter out of range");

    // Restoring divider keeps its partial remainder under the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (w_cw.op == OP_DIV_STEP)) |-> (r_rem < r_thr))
        else $error("divider remainder not below threshold");

    // A gated magnitude is always below the threshold
    a_gate_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (w_cw.op == OP_GATE_OUT)) |-> (r_quo < r_thr))
        else $error("gated sample reached the threshold");

endmodule
